FILE: design/tql_pkg.sv
// Package for the tabular Q-learning engine: item kinds, controller states, register
// addresses and the datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tql_pkg;
	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_SELECT = 2'd1,
		KIND_UPDATE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDCUR, ST_WCUR, ST_SCAN, ST_WSCAN, ST_MUL1, ST_SUM1,
		ST_MUL2, ST_SUM2, ST_WRITE, ST_DONE
	} state_t;

	localparam logic [0:0] ADDR_DISCOUNT = 1'b0;
	localparam logic [0:0] ADDR_LEARNING = 1'b1;

	typedef struct packed {
		logic load_item;
		logic rd_cur;
		logic scan_start;
		logic scan_rd;
		logic scan_cmp;
		logic mul1;
		logic sum1;
		logic mul2;
		logic sum2;
		logic wr_load;
		logic wr_upd;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic       in_range;
		logic [1:0] kind;
		logic       terminal;
		logic       scan_last;
		logic       found;
	} dp_stat_t;
endpackage
`default_nettype wire

FILE: design/tql_ctrl.sv
// Controller state machine for the Q-learning engine.
// Depends on tql_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tql_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	output tql_pkg::dp_cmd_t       cmd,
	input  tql_pkg::dp_stat_t      stat,
	output logic                   busy
);
	import tql_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					cmd.load_item = 1'b1;
					state_d = ST_RDCUR;
				end
			end
			ST_RDCUR: begin
				if (stat.kind == KIND_NONE) state_d = ST_IDLE;
				else if (!stat.in_range) state_d = ST_DONE;
				else if (stat.kind == KIND_LOAD) begin
					cmd.wr_load = 1'b1;
					state_d = ST_DONE;
				end else if (stat.kind == KIND_SELECT) begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d = ST_WCUR;
				end
			end
			ST_WCUR: begin
				cmd.scan_start = 1'b1;
				state_d = stat.terminal ? ST_MUL2 : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				state_d = ST_WSCAN;
			end
			ST_WSCAN: begin
				cmd.scan_cmp = 1'b1;
				if (stat.scan_last)
					state_d = (stat.kind == KIND_SELECT) ? ST_DONE : ST_MUL1;
				else begin
					state_d = ST_SCAN;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = ST_SUM1;
			end
			ST_SUM1: begin
				cmd.sum1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = ST_SUM2;
			end
			ST_SUM2: begin
				cmd.sum2 = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr_upd = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

FILE: design/tql_datapath.sv
// Datapath of the Q-learning engine: Q table memory, greedy scan, two
// fractional multiplies with saturation. Depends on tql_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tql_datapath #(
	parameter int NUM_OBS     = 8,
	parameter int NUM_ACTIONS = 10,
	parameter int Q_WIDTH     = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  tql_pkg::dp_cmd_t        cmd,
	output tql_pkg::dp_stat_t       stat,
	input  wire logic [1:0]         kind,
	input  wire logic [2:0]         obs_index,
	input  wire logic [3:0]         action_index,
	input  wire logic signed [31:0] value_in,
	input  wire logic [2:0]         next_obs_index,
	input  wire logic [9:0]         legal_mask,
	input  wire logic               terminal,
	input  wire logic [15:0]        gamma,
	input  wire logic [15:0]        alpha,
	output logic                    result_valid,
	output logic [3:0]              best_action,
	output logic signed [31:0]      q_out,
	output logic                    none_legal
);
	import tql_pkg::*;
	localparam int DEPTH = NUM_OBS * NUM_ACTIONS;
	localparam int AW = $clog2(DEPTH);
	localparam int W = Q_WIDTH + 18;
	localparam logic signed [W-1:0] QMAX = W'((64'sd1 <<< (Q_WIDTH - 1)) - 64'sd1);
	localparam logic signed [W-1:0] QMIN = -QMAX - W'(1);

	logic signed [Q_WIDTH-1:0] mem [DEPTH];
	logic signed [Q_WIDTH-1:0] rd_q;
	logic [1:0]  kind_q;
	logic [2:0]  s_q, s2_q;
	logic [3:0]  a_q, idx_q, best_q;
	logic [9:0]  mask_q;
	logic        term_q, found_q, none_q, valid_q;
	logic signed [31:0] val_q;
	logic signed [Q_WIDTH-1:0] cur_q, max_q, u_q, q_q;
	logic signed [W-1:0] prod_q;

	function automatic logic signed [Q_WIDTH-1:0] sat(input logic signed [W-1:0] v);
		if (v > QMAX) return QMAX[Q_WIDTH-1:0];
		if (v < QMIN) return QMIN[Q_WIDTH-1:0];
		return v[Q_WIDTH-1:0];
	endfunction

	logic in_range;
	logic [AW-1:0] addr_sa, addr_scan, rd_addr;
	logic [AW+3:0] sa_full, scan_full;
	always_comb begin
		sa_full = (AW+4)'(s_q) * (AW+4)'(NUM_ACTIONS) + (AW+4)'(a_q);
		scan_full = (AW+4)'((kind_q == KIND_SELECT) ? s_q : s2_q) * (AW+4)'(NUM_ACTIONS)
			+ (AW+4)'(idx_q);
		addr_sa = sa_full[AW-1:0];
		addr_scan = scan_full[AW-1:0];
		rd_addr = cmd.rd_cur ? addr_sa : addr_scan;
		case (kind_q)
			KIND_LOAD:   in_range = (32'(s_q) < NUM_OBS) && (32'(a_q) < NUM_ACTIONS);
			KIND_SELECT: in_range = (32'(s_q) < NUM_OBS);
			default:     in_range = (32'(s_q) < NUM_OBS) && (32'(a_q) < NUM_ACTIONS)
				&& (32'(s2_q) < NUM_OBS);
		endcase
	end

	logic signed [W-1:0] load_w;
	assign load_w = W'(val_q);

	always_ff @(posedge clk) begin
		if (cmd.rd_cur || cmd.scan_rd) rd_q <= mem[rd_addr];
		if (cmd.wr_load) mem[addr_sa] <= sat(load_w);
		if (cmd.wr_upd) mem[addr_sa] <= q_q;
	end

	logic signed [W-1:0] mul_a;
	logic [15:0] mul_f;
	logic signed [W-1:0] diff_w;
	assign diff_w = W'(u_q) - W'(cur_q);
	assign mul_a = cmd.mul1 ? W'(max_q) : diff_w;
	assign mul_f = cmd.mul1 ? gamma : alpha;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind; s_q <= obs_index; a_q <= action_index; val_q <= value_in;
			s2_q <= next_obs_index; mask_q <= legal_mask; term_q <= terminal;
		end
		if (cmd.scan_start) cur_q <= rd_q;
		if (cmd.scan_start) begin
			idx_q <= '0; found_q <= 1'b0; best_q <= '0; max_q <= '0;
			q_q <= '0; none_q <= 1'b0; u_q <= Q_WIDTH'(val_q);
		end
		if (cmd.scan_cmp) begin
			if (mask_q[idx_q] && (!found_q || rd_q > max_q)) begin
				max_q <= rd_q; best_q <= idx_q; found_q <= 1'b1;
			end
			idx_q <= idx_q + 4'd1;
		end
		if (cmd.mul1 || cmd.mul2) prod_q <= (mul_a * $signed({1'b0, mul_f})) >>> 16;
		if (cmd.sum1) begin
			if (found_q) u_q <= sat(W'(val_q) + prod_q);
			else none_q <= 1'b1;
		end
		if (cmd.sum2) q_q <= sat(W'(cur_q) + prod_q);
		if (cmd.wr_load) q_q <= sat(load_w);
		if (cmd.load_item) begin q_q <= '0; best_q <= '0; none_q <= 1'b0; end
		if (cmd.scan_cmp && stat.scan_last && kind_q == KIND_SELECT) begin
			if (mask_q[idx_q] && (!found_q || rd_q > max_q)) q_q <= rd_q;
			else if (found_q) q_q <= max_q;
			else none_q <= 1'b1;
		end
	end

	// best_action is reported with every result; it reads zero when no legal action was found
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= cmd.emit;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			best_action <= best_q;
			q_out <= 32'(q_q);
			none_legal <= none_q;
		end
	end
	assign result_valid = valid_q;

	logic last_idx;
	assign last_idx = (32'(idx_q) == NUM_ACTIONS - 1);
	assign stat.in_range = in_range;
	assign stat.kind = kind_q;
	assign stat.terminal = term_q;
	assign stat.scan_last = last_idx;
	assign stat.found = found_q;
endmodule
`default_nettype wire

FILE: design/tabular_q_learning_engine.sv
// Top level of the tabular Q-learning engine: APB registers, controller and
// datapath. Depends on tql_pkg, tql_ctrl, tql_datapath.
//
// channel   signals                                    handshake
// item in   kind obs_index action_index value_in ...   start & !busy
// result    best_action q_out none_legal               done, one cycle
// config    psel penable pwrite paddr pwdata prdata    APB, pready high
//
// Selects and updates scan a row serially through one registered memory read
// port, and that scan sets their run time; terminal updates skip the scan.
// Reset clears the controller state and done and loads the default rates;
// datapath registers and table contents are undefined until loaded.
// The result receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module tabular_q_learning_engine #(
	parameter int NUM_OBS     = 8,
	parameter int NUM_ACTIONS = 10,
	parameter int Q_WIDTH     = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [2:0]         obs_index,
	input  wire logic [3:0]         action_index,
	input  wire logic signed [31:0] value_in,
	input  wire logic [2:0]         next_obs_index,
	input  wire logic [9:0]         legal_mask,
	input  wire logic               terminal,
	output logic                    done,
	output logic [3:0]              best_action,
	output logic signed [31:0]      q_out,
	output logic                    none_legal,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import tql_pkg::*;
	logic [15:0] gamma_q, alpha_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= 16'd62259;
			alpha_q <= 16'd55706;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == ADDR_DISCOUNT) gamma_q <= pwdata[15:0];
			else alpha_q <= pwdata[15:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == ADDR_LEARNING) prdata = {16'd0, alpha_q};
			else prdata = {16'd0, gamma_q};
		end
	end

	tql_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(start), .cmd(cmd), .stat(stat), .busy(busy)
	);

	tql_datapath #(.NUM_OBS(NUM_OBS), .NUM_ACTIONS(NUM_ACTIONS), .Q_WIDTH(Q_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .kind(kind),
		.obs_index(obs_index), .action_index(action_index), .value_in(value_in),
		.next_obs_index(next_obs_index), .legal_mask(legal_mask), .terminal(terminal),
		.gamma(gamma_q), .alpha(alpha_q), .result_valid(done), .best_action(best_action),
		.q_out(q_out), .none_legal(none_legal)
	);

	a_no_accept_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(start && !busy)) else $error("result right after accept");
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");
	a_none_zero_action: assert property (@(posedge clk) disable iff (!arst_n)
		done && none_legal |-> best_action == 4'd0) else $error("action with none legal");
endmodule
`default_nettype wire

FILE: tb/tabular_q_learning_engine_tb.sv
// Self-checking testbench for tabular_q_learning_engine: loads, greedy selects
// and Q updates under several discount and learning rates, checked against a
// built-in predictor of the Q table. Depends on tql_pkg and the engine RTL.
`timescale 1ns / 1ps
`default_nettype none
module tabular_q_learning_engine_tb;
	import tql_pkg::*;

	localparam int NOBS = 8;
	localparam int NACT = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		kind_t            kind;
		logic [2:0]       obs;
		logic [3:0]       act;
		logic signed [31:0] value;
		logic [2:0]       next_obs;
		logic [9:0]       mask;
		logic             term;
	} step_item_t;

	typedef struct {
		logic [3:0]  best;
		logic [31:0] q;
		logic        none;
	} q_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = '0;
	logic [2:0] obs_index = '0;
	logic [3:0] action_index = '0;
	logic signed [31:0] value_in = '0;
	logic [2:0] next_obs_index = '0;
	logic [9:0] legal_mask = '0;
	logic terminal = 1'b0;
	logic done;
	logic [3:0] best_action;
	logic signed [31:0] q_out;
	logic none_legal;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tabular_q_learning_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.obs_index(obs_index), .action_index(action_index), .value_in(value_in),
		.next_obs_index(next_obs_index), .legal_mask(legal_mask), .terminal(terminal),
		.done(done), .best_action(best_action), .q_out(q_out), .none_legal(none_legal),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	step_item_t pending_items[$];
	q_result_t expected_results[$];
	longint q_model[NOBS][NACT];
	bit [9:0] loaded_cols[NOBS];
	logic [15:0] gamma_frac = 16'd62259;
	logic [15:0] alpha_frac = 16'd55706;
	int mismatches = 0;
	int cycles = 0;
	int gap = 0;
	bit gaps_on = 1'b1;
	bit taken = 1'b0;
	step_item_t cur;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_frac(longint a, logic [15:0] f);
		return (a * longint'({48'd0, f})) >>> 16;
	endfunction

	function automatic bit best_in_row(int row, logic [9:0] mask, output logic [3:0] act,
			output longint val);
		bit found;
		found = 1'b0;
		act = '0;
		val = 0;
		for (int i = 0; i < NACT; i++) begin
			if (mask[i] && (!found || q_model[row][i] > val)) begin
				val = q_model[row][i];
				act = 4'(i);
				found = 1'b1;
			end
		end
		return found;
	endfunction

	function automatic bit apply_step(step_item_t it, output q_result_t r);
		longint u, cur_q, mx, qv;
		logic [3:0] ba;
		r.best = '0;
		r.q = '0;
		r.none = 1'b0;
		qv = 0;
		if (it.kind == KIND_NONE) return 1'b0;
		case (it.kind)
			KIND_LOAD: begin
				if (it.act < NACT) begin
					qv = sat32(longint'(it.value));
					q_model[it.obs][it.act] = qv;
				end
			end
			KIND_SELECT: begin
				if (!best_in_row(it.obs, it.mask, ba, qv)) r.none = 1'b1;
				r.best = ba;
			end
			default: begin
				if (it.act < NACT) begin
					u = longint'(it.value);
					cur_q = q_model[it.obs][it.act];
					if (!it.term) begin
						if (best_in_row(it.next_obs, it.mask, ba, mx)) begin
							u = sat32(u + scale_frac(mx, gamma_frac));
							r.best = ba;
						end else begin
							r.none = 1'b1;
						end
					end
					qv = sat32(cur_q + scale_frac(u - cur_q, alpha_frac));
					q_model[it.obs][it.act] = qv;
				end
			end
		endcase
		r.q = qv[31:0];
		return 1'b1;
	endfunction

	task automatic queue_item(kind_t k, int s, int a, logic [31:0] v, int s2,
			logic [9:0] m, bit t);
		step_item_t it;
		it.kind = k;
		it.obs = 3'(s);
		it.act = 4'(a);
		it.value = v;
		it.next_obs = 3'(s2);
		it.mask = m;
		it.term = t;
		if (k == KIND_SELECT) it.mask = m & loaded_cols[s];
		if (k == KIND_UPDATE && a < NACT) begin
			if (!loaded_cols[s][a]) it.kind = KIND_LOAD;
			else if (!t) it.mask = m & loaded_cols[s2];
		end
		if (it.kind == KIND_LOAD && a < NACT) loaded_cols[s][a] = 1'b1;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 20)) - 10) << 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_random(int n);
		int r, a;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			a = ($urandom_range(0, 15) == 0) ? $urandom_range(NACT, 15)
				: $urandom_range(0, NACT - 1);
			if (r < 2)
				queue_item(KIND_NONE, $urandom_range(0, 7), a, $urandom,
					$urandom_range(0, 7), 10'($urandom), 1'($urandom_range(0, 1)));
			else if (r < 32)
				queue_item(KIND_LOAD, $urandom_range(0, 7), a, pick_value(), 0, '0, 0);
			else if (r < 60)
				queue_item(KIND_SELECT, $urandom_range(0, 7), a, $urandom,
					$urandom_range(0, 7),
					($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom), 0);
			else
				queue_item(KIND_UPDATE, $urandom_range(0, 7), a, pick_value(),
					$urandom_range(0, 7),
					($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom),
					$urandom_range(0, 3) == 0);
		end
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_rates(logic [15:0] g, logic [15:0] a);
		drain();
		reg_write({ADDR_DISCOUNT, 2'b00}, {16'($urandom), g});
		reg_write({ADDR_LEARNING, 2'b00}, 32'(a));
		gamma_frac = g;
		alpha_frac = a;
	endtask

	always @(posedge clk) begin
		taken <= start && !busy;
		if (arst_n && start && !busy) begin
			q_result_t r;
			if (apply_step(cur, r)) expected_results.push_back(r);
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !taken) begin
			end else if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				step_item_t it;
				it = pending_items.pop_front();
				cur <= it;
				kind <= it.kind;
				obs_index <= it.obs;
				action_index <= it.act;
				value_in <= it.value;
				next_obs_index <= it.next_obs;
				legal_mask <= it.mask;
				terminal <= it.term;
				start <= 1'b1;
				if (gaps_on && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 8);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: best=%0d q=%h none=%b",
					best_action, q_out, none_legal);
			end else begin
				q_result_t e;
				e = expected_results.pop_front();
				if (e.best !== best_action || e.q !== q_out || e.none !== none_legal) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected best=%0d q=%h none=%b, got best=%0d q=%h none=%b",
							e.best, e.q, e.none, best_action, q_out, none_legal);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tabular_q_learning_engine_tb NOT OK");
			$finish;
		end
	end

	initial begin
		for (int s = 0; s < NOBS; s++) begin
			loaded_cols[s] = '0;
			for (int a = 0; a < NACT; a++) q_model[s][a] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, ties, empty masks, out-of-range columns, unknown kind
		queue_item(KIND_LOAD, 0, 0, 32'h7FFF_FFFF, 0, '0, 0);
		queue_item(KIND_LOAD, 0, 1, 32'h8000_0000, 0, '0, 0);
		queue_item(KIND_LOAD, 0, 2, 32'h7FFF_FFFF, 0, '0, 0);
		queue_item(KIND_LOAD, 0, 9, 32'h0001_0000, 0, '0, 0);
		queue_item(KIND_LOAD, 7, 3, 32'h0000_0000, 0, '0, 0);
		queue_item(KIND_LOAD, 7, 9, 32'hFFFF_0000, 0, '0, 0);
		queue_item(KIND_LOAD, 7, 15, 32'h1234_5678, 0, '0, 0);
		queue_item(KIND_SELECT, 0, 0, '0, 0, 10'h3FF, 0);
		queue_item(KIND_SELECT, 0, 0, '0, 0, 10'h000, 0);
		queue_item(KIND_SELECT, 0, 0, '0, 0, 10'h202, 0);
		queue_item(KIND_SELECT, 7, 0, '0, 0, 10'h208, 0);
		queue_item(KIND_UPDATE, 0, 9, 32'h7FFF_FFFF, 0, 10'h3FF, 0);
		queue_item(KIND_UPDATE, 0, 1, 32'h8000_0000, 0, 10'h002, 0);
		queue_item(KIND_UPDATE, 7, 3, 32'h0003_0000, 0, '0, 1);
		queue_item(KIND_UPDATE, 7, 9, 32'hFFFE_0000, 7, 10'h000, 0);
		queue_item(KIND_UPDATE, 7, 12, 32'h0001_0000, 0, 10'h3FF, 0);
		queue_item(KIND_NONE, 0, 0, 32'h7FFF_FFFF, 0, 10'h3FF, 1);
		queue_item(KIND_SELECT, 3, 15, '0, 0, 10'h3FF, 0);
		queue_random(80);

		set_rates(16'd0, 16'd0);
		queue_random(100);
		set_rates(16'hFFFF, 16'hFFFF);
		queue_random(100);
		set_rates(16'd0, 16'hFFFF);
		queue_random(100);
		set_rates(16'hFFFF, 16'd0);
		queue_random(100);
		set_rates(16'($urandom), 16'($urandom));
		queue_random(100);
		set_rates(16'd62259, 16'd55706);
		gaps_on = 1'b0;
		queue_random(100);
		drain();

		if (mismatches == 0) begin
			$display("tabular_q_learning_engine_tb OK");
		end else begin
			$display("tabular_q_learning_engine_tb NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
design/tql_pkg.sv
design/tql_ctrl.sv
design/tql_datapath.sv
design/tabular_q_learning_engine.sv
tb/tabular_q_learning_engine_tb.sv
